[sv/srp_pkg.sv]
// Shared constants, types and a helper function of the sample region player.
package srp_pkg;

    localparam int SAMPLE_DEPTH = 65536;
    localparam int SAMPLE_BITS  = 16;

    localparam int AW         = $clog2(SAMPLE_DEPTH);
    localparam int EL_W       = $clog2(SAMPLE_DEPTH + 1);
    localparam int POS_W      = 40;
    localparam int POS_FRAC   = 16;
    localparam int IDX_W      = POS_W - POS_FRAC;
    localparam int MIX_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_TRIGGER = 2'd1;
    localparam logic [1:0] MODE_STOP    = 2'd2;
    localparam logic [1:0] MODE_TICK    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FRACTION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_FRACTION   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_RATE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_LEFT_GAIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_RIGHT_GAIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE    = 3'd7;

    localparam logic [16:0] RST_SAMPLE_LENGTH  = 17'd0;
    localparam logic [15:0] RST_START_FRACTION = 16'd0;
    localparam logic [16:0] RST_END_FRACTION   = 17'd65536;
    localparam logic [23:0] RST_PITCH_RATE     = 24'd65536;
    localparam logic [15:0] RST_VOLUME         = 16'd32768;
    localparam logic [15:0] RST_PAN_GAIN       = 16'd23170;

    localparam logic signed [MIX_W-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [MIX_W-1:0] OUT_MIN = 24'sh800000;

    typedef logic signed [MIX_W-1:0]       t_mix;
    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic st1;
        logic st2;
    } t_mix_ctl;

    function automatic t_sample to_store(input logic signed [15:0] v);
        logic signed [39:0] w;
        w = 40'(v);
        w = w <<< SAMPLE_BITS;
        return SAMPLE_BITS'(w >>> 16);
    endfunction

endpackage

[sv/srp_if.sv]
// Handshake channels of the sample region player: input item and result beat.
interface srp_in_if;
    import srp_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [15:0]        address;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    t_mix               mix_left;
    t_mix               mix_right;

    modport source (output valid, mode, address, sample_left, sample_right, mix_left,
                    mix_right, input ready);
    modport sink (input valid, mode, address, sample_left, sample_right, mix_left,
                  mix_right, output ready);
endinterface

interface srp_out_if;
    import srp_pkg::*;
    logic              valid;
    logic              ready;
    t_mix              out_left;
    t_mix              out_right;
    logic              is_playing;
    logic [IDX_W-1:0]  position;

    modport source (output valid, out_left, out_right, is_playing, position, input ready);
    modport sink (input valid, out_left, out_right, is_playing, position, output ready);
endinterface

[sv/sample_region_player.sv]
// Top level of the stereo sample region player voice.
//
//  channel   dir  handshake        beat contents
//  i_in      in   valid / ready    mode, address, sample pair, mix pair
//  o_out     out  valid / ready    mixed pair, playing flag, integer position
//  i_cfg_*   in   write enable     register index and data, no read-back
//
// A tick that plays a sample passes check and memory read, two multiply stages, then round,
// saturate and load the output register. Other items go from the check straight to the
// output register load. Ready returns in the cycle after the output register loads. One item
// is in flight at a time, set by the single sample memory port and the shared multiply chain
// per channel. Reset is synchronous and clears control state and registers; sample memory
// is not cleared. A result that is not taken holds the next item in its final cycle until
// the output frees.
module sample_region_player (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [srp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [srp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    srp_in_if.sink                              i_in,
    srp_out_if.source                           o_out
);
    import srp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MUL1  = 3'd2;
    localparam logic [2:0] S_MUL2  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [16:0] r_sample_length;
    logic [15:0] r_start_fraction;
    logic [16:0] r_end_fraction;
    logic [23:0] r_pitch_rate;
    logic [15:0] r_volume;
    logic [15:0] r_pan_left_gain;
    logic [15:0] r_pan_right_gain;
    logic        r_loop_enable;

    logic [2:0]       r_state, n_state;
    logic             r_playing, n_playing;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_go, n_go;
    logic             r_out_valid;

    logic [1:0]           r_mode;
    logic [15:0]          r_addr;
    logic signed [15:0]   r_sl, r_sr;
    t_mix                 r_mix_l, r_mix_r;
    logic [IDX_W-1:0]     r_idx;
    logic [EL_W-1:0]      r_start_idx;
    logic [EL_W:0]        r_end_idx;
    t_mix                 r_out_l, r_out_r;
    logic                 r_out_play;
    logic [IDX_W-1:0]     r_out_pos;

    logic [EL_W-1:0]      w_len;
    logic [16+EL_W-1:0]   w_start_prod;
    logic [17+EL_W-1:0]   w_end_prod;
    logic [IDX_W-1:0]     w_idx, w_play_idx;
    logic                 w_active, w_hit_end, w_wrap, w_addr_ok;
    logic                 w_accept, w_load_out;
    logic                 w_ram_we;
    logic [AW-1:0]        w_ram_addr;
    logic [2*SAMPLE_BITS-1:0] w_wdata, w_rdata;
    t_mix_ctl             w_ctl;
    t_mix                 w_res_l, w_res_r;

    assign w_len = (32'(r_sample_length) < 32'(SAMPLE_DEPTH)) ? EL_W'(r_sample_length)
                                                               : EL_W'(SAMPLE_DEPTH);
    assign w_start_prod = r_start_fraction * w_len;
    assign w_end_prod   = r_end_fraction * w_len;

    assign w_accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE) && i_rst_n;
    assign w_load_out = (r_state == S_FIN) && (!r_out_valid || o_out.ready);

    always_comb begin
        w_idx      = r_pos[POS_W-1:POS_FRAC];
        w_active   = (r_mode == MODE_TICK) && r_playing && (w_len != '0);
        w_hit_end  = (w_idx >= IDX_W'(r_end_idx)) || (w_idx >= IDX_W'(w_len));
        w_wrap     = w_active && w_hit_end;
        w_play_idx = w_wrap ? IDX_W'(r_start_idx) : w_idx;
        w_addr_ok  = 32'(r_addr) < 32'(SAMPLE_DEPTH);
        w_ram_we   = (r_state == S_CHECK) && (r_mode == MODE_LOAD) && w_addr_ok;
        w_ram_addr = (r_mode == MODE_LOAD) ? AW'(r_addr) : AW'(w_play_idx);
        w_wdata    = {to_store(r_sl), to_store(r_sr)};
        w_ctl.st1  = (r_state == S_MUL1);
        w_ctl.st2  = (r_state == S_MUL2);
    end

    always_comb begin
        n_state   = r_state;
        n_playing = r_playing;
        n_pos     = r_pos;
        n_go      = r_go;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_go    = 1'b0;
                n_state = S_FIN;
                case (r_mode)
                    MODE_LOAD: begin
                        n_playing = 1'b0;
                        n_pos     = '0;
                    end
                    MODE_TRIGGER: begin
                        if (w_len != '0) begin
                            n_playing = 1'b1;
                            n_pos     = {IDX_W'(r_start_idx), {POS_FRAC{1'b0}}};
                        end
                    end
                    MODE_STOP: begin
                        n_playing = 1'b0;
                    end
                    default: begin
                        if (w_active) begin
                            if (w_hit_end && !r_loop_enable) begin
                                n_playing = 1'b0;
                            end else begin
                                n_go    = 1'b1;
                                n_state = S_MUL1;
                                n_pos   = (w_wrap ? {IDX_W'(r_start_idx), {POS_FRAC{1'b0}}}
                                                  : r_pos)
                                          + POS_W'(r_pitch_rate);
                            end
                        end
                    end
                endcase
            end
            S_MUL1: begin
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_playing        <= 1'b0;
            r_pos            <= '0;
            r_go             <= 1'b0;
            r_out_valid      <= 1'b0;
            r_sample_length  <= RST_SAMPLE_LENGTH;
            r_start_fraction <= RST_START_FRACTION;
            r_end_fraction   <= RST_END_FRACTION;
            r_pitch_rate     <= RST_PITCH_RATE;
            r_volume         <= RST_VOLUME;
            r_pan_left_gain  <= RST_PAN_GAIN;
            r_pan_right_gain <= RST_PAN_GAIN;
            r_loop_enable    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_playing <= n_playing;
            r_pos     <= n_pos;
            r_go      <= n_go;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SAMPLE_LENGTH:  r_sample_length  <= i_cfg_data[16:0];
                    CFG_START_FRACTION: r_start_fraction <= i_cfg_data[15:0];
                    CFG_END_FRACTION:   r_end_fraction   <= i_cfg_data[16:0];
                    CFG_PITCH_RATE:     r_pitch_rate     <= i_cfg_data[23:0];
                    CFG_VOLUME:         r_volume         <= i_cfg_data[15:0];
                    CFG_PAN_LEFT_GAIN:  r_pan_left_gain  <= i_cfg_data[15:0];
                    CFG_PAN_RIGHT_GAIN: r_pan_right_gain <= i_cfg_data[15:0];
                    CFG_LOOP_ENABLE:    r_loop_enable    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_start_idx <= w_start_prod[16+EL_W-1:16];
        r_end_idx   <= w_end_prod[17+EL_W-1:16];
        if (w_accept) begin
            r_mode  <= i_in.mode;
            r_addr  <= i_in.address;
            r_sl    <= i_in.sample_left;
            r_sr    <= i_in.sample_right;
            r_mix_l <= i_in.mix_left;
            r_mix_r <= i_in.mix_right;
        end
        if (r_state == S_CHECK) begin
            r_idx <= w_play_idx;
        end
        if (w_load_out) begin
            r_out_l    <= r_go ? w_res_l : r_mix_l;
            r_out_r    <= r_go ? w_res_r : r_mix_r;
            r_out_play <= r_playing;
            r_out_pos  <= r_pos[POS_W-1:POS_FRAC];
        end
    end

    srp_ram #(
        .WIDTH(2 * SAMPLE_BITS),
        .DEPTH(SAMPLE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_addr (w_ram_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    srp_mix u_mix_l (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_sample(w_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_volume(r_volume),
        .i_gain  (r_pan_left_gain),
        .i_mix   (r_mix_l),
        .o_result(w_res_l)
    );

    srp_mix u_mix_r (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_sample(w_rdata[SAMPLE_BITS-1:0]),
        .i_volume(r_volume),
        .i_gain  (r_pan_right_gain),
        .i_mix   (r_mix_r),
        .o_result(w_res_r)
    );

    assign o_out.valid      = r_out_valid;
    assign o_out.out_left   = r_out_l;
    assign o_out.out_right  = r_out_r;
    assign o_out.is_playing = r_out_play;
    assign o_out.position   = r_out_pos;

    a_ram_write_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == S_CHECK) && (r_mode == MODE_LOAD))
        else $error("Sample memory written outside a load item.");

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CHECK) && (r_mode == MODE_STOP)) |=> !r_playing)
        else $error("Stop item left the voice playing.");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL1) |-> r_go && (r_idx < IDX_W'(w_len)))
        else $error("Sample read beyond the loaded length.");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> r_out_valid && (r_state == S_IDLE))
        else $error("Finished item did not reach the output register.");
endmodule

[sv/srp_ram.sv]
// Generic single-port RAM with registered read data.
module srp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/srp_mix.sv]
// One channel of the voice datapath: two multiply stages, rounding and saturating mix.
module srp_mix (
    input  logic                             i_clk,
    input  srp_pkg::t_mix_ctl                i_ctl,
    input  logic signed [srp_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [15:0]                      i_volume,
    input  logic [15:0]                      i_gain,
    input  logic signed [srp_pkg::MIX_W-1:0] i_mix,
    output logic signed [srp_pkg::MIX_W-1:0] o_result
);
    import srp_pkg::*;

    localparam int P1_W = SAMPLE_BITS + 17;
    localparam int P2_W = P1_W + 17;
    localparam int SH   = SAMPLE_BITS + 6;
    localparam int C_W  = P2_W + 1 - SH;
    localparam logic signed [P2_W:0] RND = (P2_W + 1)'(1) <<< (SH - 1);

    logic signed [P1_W-1:0] r_p1;
    logic signed [P2_W-1:0] r_p2;
    logic signed [P2_W:0]   w_round;
    logic signed [C_W-1:0]  w_c;
    logic signed [C_W:0]    w_sum;
    logic [C_W-MIX_W+1:0]   w_top;

    always_ff @(posedge i_clk) begin
        if (i_ctl.st1) begin
            r_p1 <= P1_W'(i_sample * $signed({1'b0, i_volume}));
        end
        if (i_ctl.st2) begin
            r_p2 <= P2_W'(r_p1 * $signed({1'b0, i_gain}));
        end
    end

    always_comb begin
        w_round = (P2_W + 1)'(r_p2) + RND;
        w_c     = $signed(w_round[P2_W:SH]);
        w_sum   = (C_W + 1)'(i_mix) + (C_W + 1)'(w_c);
        w_top   = w_sum[C_W:MIX_W-1];
        if ((&w_top) || !(|w_top)) begin
            o_result = w_sum[MIX_W-1:0];
        end else if (w_sum[C_W]) begin
            o_result = OUT_MIN;
        end else begin
            o_result = OUT_MAX;
        end
    end
endmodule

[sim/tb_srp_checker.sv]
// Scoreboard that predicts every result beat of the sample region player and checks it.
`timescale 1ns / 1ps
module tb_srp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [srp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    srp_in_if                              i_in_mon,
    srp_out_if                             i_out_mon,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_checked
);
    import srp_pkg::*;

    typedef struct packed {
        t_mix             out_left;
        t_mix             out_right;
        logic             is_playing;
        logic [IDX_W-1:0] position;
    } t_voice_beat;

    t_voice_beat pending_outputs[$];

    logic [16:0]      length_reg;
    logic [15:0]      start_reg;
    logic [16:0]      end_reg;
    logic [23:0]      pitch_reg;
    logic [15:0]      volume_reg;
    logic [15:0]      pan_left_reg;
    logic [15:0]      pan_right_reg;
    logic             loop_reg;

    int               left_words[SAMPLE_DEPTH];
    int               right_words[SAMPLE_DEPTH];
    logic [POS_W-1:0] play_pos;
    logic             voice_on;

    function automatic int stored_word(input logic signed [15:0] raw);
        if (SAMPLE_BITS >= 16) return int'(raw) * (1 << (SAMPLE_BITS - 16));
        return int'(raw) >>> (16 - SAMPLE_BITS);
    endfunction

    // Rounds the voice contribution half up to Q1.23 and saturates the sum with the bus.
    function automatic t_mix mix_in(input t_mix bus, input int word, input logic [15:0] gain);
        longint prod;
        longint total;
        prod  = longint'(word) * longint'(volume_reg) * longint'(gain);
        total = longint'(bus)
                + ((prod + (longint'(1) <<< (SAMPLE_BITS + 5))) >>> (SAMPLE_BITS + 6));
        if (total > longint'(OUT_MAX)) total = longint'(OUT_MAX);
        if (total < longint'(OUT_MIN)) total = longint'(OUT_MIN);
        return t_mix'(total);
    endfunction

    function automatic t_voice_beat predict_voice(input logic [1:0] mode,
                                                  input logic [15:0] addr,
                                                  input logic signed [15:0] smp_l,
                                                  input logic signed [15:0] smp_r,
                                                  input t_mix mix_l,
                                                  input t_mix mix_r);
        longint unsigned len;
        longint unsigned start_idx;
        longint unsigned end_idx;
        longint unsigned idx;
        logic            sounds;
        t_voice_beat     beat;
        beat.out_left  = mix_l;
        beat.out_right = mix_r;
        len       = (length_reg > SAMPLE_DEPTH) ? SAMPLE_DEPTH : length_reg;
        start_idx = (start_reg * len) >> 16;
        case (mode)
            MODE_LOAD: begin
                if (addr < SAMPLE_DEPTH) begin
                    left_words[addr]  = stored_word(smp_l);
                    right_words[addr] = stored_word(smp_r);
                end
                voice_on = 1'b0;
                play_pos = '0;
            end
            MODE_TRIGGER: begin
                if (len != 0) begin
                    play_pos = POS_W'(start_idx) << POS_FRAC;
                    voice_on = 1'b1;
                end
            end
            MODE_STOP: begin
                voice_on = 1'b0;
            end
            MODE_TICK: begin
                if (voice_on && len != 0) begin
                    end_idx = (end_reg * len) >> 16;
                    idx     = play_pos >> POS_FRAC;
                    sounds  = 1'b1;
                    if (idx >= end_idx || idx >= len) begin
                        if (loop_reg) begin
                            idx      = start_idx;
                            play_pos = POS_W'(start_idx) << POS_FRAC;
                        end else begin
                            voice_on = 1'b0;
                            sounds   = 1'b0;
                        end
                    end
                    if (sounds && idx < SAMPLE_DEPTH) begin
                        beat.out_left  = mix_in(mix_l, left_words[idx], pan_left_reg);
                        beat.out_right = mix_in(mix_r, right_words[idx], pan_right_reg);
                        play_pos       = play_pos + POS_W'(pitch_reg);
                    end
                end
            end
            default: begin
            end
        endcase
        beat.is_playing = voice_on;
        beat.position   = play_pos[POS_W-1:POS_FRAC];
        return beat;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH %s", msg);
        o_errors++;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s: got %0d, expected %0d",
                                      o_checked, name, got, want));
    endtask

    always @(posedge i_clk) begin : track
        t_voice_beat want;
        if (!i_rst_n) begin
            length_reg    = RST_SAMPLE_LENGTH;
            start_reg     = RST_START_FRACTION;
            end_reg       = RST_END_FRACTION;
            pitch_reg     = RST_PITCH_RATE;
            volume_reg    = RST_VOLUME;
            pan_left_reg  = RST_PAN_GAIN;
            pan_right_reg = RST_PAN_GAIN;
            loop_reg      = 1'b0;
            play_pos      = '0;
            voice_on      = 1'b0;
            pending_outputs.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SAMPLE_LENGTH:  length_reg    = i_cfg_data[16:0];
                    CFG_START_FRACTION: start_reg     = i_cfg_data[15:0];
                    CFG_END_FRACTION:   end_reg       = i_cfg_data[16:0];
                    CFG_PITCH_RATE:     pitch_reg     = i_cfg_data[23:0];
                    CFG_VOLUME:         volume_reg    = i_cfg_data[15:0];
                    CFG_PAN_LEFT_GAIN:  pan_left_reg  = i_cfg_data[15:0];
                    CFG_PAN_RIGHT_GAIN: pan_right_reg = i_cfg_data[15:0];
                    CFG_LOOP_ENABLE:    loop_reg      = i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready)
                pending_outputs.push_back(predict_voice(i_in_mon.mode, i_in_mon.address,
                                                        i_in_mon.sample_left,
                                                        i_in_mon.sample_right,
                                                        i_in_mon.mix_left,
                                                        i_in_mon.mix_right));
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (pending_outputs.size() == 0) begin
                    report_mismatch($sformatf("beat %0d arrived with nothing expected",
                                              o_checked));
                end else begin
                    want = pending_outputs.pop_front();
                    check_field("out_left", i_out_mon.out_left, want.out_left);
                    check_field("out_right", i_out_mon.out_right, want.out_right);
                    check_field("is_playing", {31'd0, i_out_mon.is_playing},
                                {31'd0, want.is_playing});
                    check_field("position", {8'd0, i_out_mon.position},
                                {8'd0, want.position});
                end
                o_checked++;
            end
        end
        o_pending = pending_outputs.size();
    end

endmodule

[sim/tb_sample_region_player.sv]
// Testbench top of the sample region player: clock, reset, stimulus, handshakes and verdict.
`timescale 1ns / 1ps
module tb_sample_region_player;
    import srp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 320;
    localparam int LOW_WORDS    = 32;
    localparam int HIGH_BASE    = SAMPLE_DEPTH - 16;

    typedef struct {
        logic [16:0] length;
        logic [15:0] start_frac;
        logic [16:0] end_frac;
        logic [23:0] pitch;
        logic [15:0] volume;
        logic [15:0] pan_left;
        logic [15:0] pan_right;
        logic        loop_on;
    } t_voice_setting;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    srp_in_if  in_bus ();
    srp_out_if out_bus ();

    int errors;
    int pending;
    int checked;
    int cycle_count;
    int n_load;
    int n_trigger;
    int n_stop;
    int n_tick;
    int n_settings;
    bit src_idle_on;
    bit sink_idle_on;

    sample_region_player dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    tb_srp_checker voice_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_mon    (in_bus),
        .i_out_mon   (out_bus),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
        $display("simulation failed");
        $finish;
    end

    // While sink idling is on, the result side may hold ready low for a random stall before each beat.
    initial begin : result_sink
        int stall;
        out_bus.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = sink_idle_on ? $urandom_range(0, 5) : 0;
            if (stall != 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_bus.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    function automatic t_mix rand_mix();
        case ($urandom_range(0, 7))
            0: return OUT_MAX;
            1: return OUT_MIN;
            default: return t_mix'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // Lengths stay within the preloaded low words so that no unwritten word is ever read.
    function automatic t_voice_setting random_setting();
        t_voice_setting s;
        case ($urandom_range(0, 5))
            0: s.length = 17'd0;
            1: s.length = 17'd1;
            2: s.length = 17'(LOW_WORDS);
            default: s.length = 17'($urandom_range(1, LOW_WORDS));
        endcase
        case ($urandom_range(0, 5))
            0: s.start_frac = 16'd0;
            1: s.start_frac = 16'hFFFF;
            default: s.start_frac = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: s.end_frac = 17'd0;
            1: s.end_frac = 17'd65536;
            default: s.end_frac = 17'($urandom_range(0, 65536));
        endcase
        case ($urandom_range(0, 5))
            0: s.pitch = 24'd0;
            1: s.pitch = 24'hFFFFFF;
            2: s.pitch = 24'($urandom);
            default: s.pitch = 24'($urandom_range(4096, 3 * 65536));
        endcase
        s.volume    = rand_gain();
        s.pan_left  = rand_gain();
        s.pan_right = rand_gain();
        s.loop_on   = ($urandom_range(0, 3) != 0);
        return s;
    endfunction

    task automatic play_item(input logic [1:0] mode, input logic [15:0] addr,
                             input logic signed [15:0] smp_l,
                             input logic signed [15:0] smp_r,
                             input t_mix mix_l, input t_mix mix_r);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 5) : 0;
        if (gap != 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid        <= 1'b1;
        in_bus.mode         <= mode;
        in_bus.address      <= addr;
        in_bus.sample_left  <= smp_l;
        in_bus.sample_right <= smp_r;
        in_bus.mix_left     <= mix_l;
        in_bus.mix_right    <= mix_r;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        case (mode)
            MODE_LOAD:    n_load++;
            MODE_TRIGGER: n_trigger++;
            MODE_STOP:    n_stop++;
            MODE_TICK:    n_tick++;
            default: begin
            end
        endcase
        @(negedge i_clk);
    endtask

    task automatic command(input logic [1:0] mode);
        play_item(mode, 16'($urandom), rand_word(), rand_word(), rand_mix(), rand_mix());
    endtask

    task automatic load_word(input logic [15:0] addr, input logic signed [15:0] smp_l,
                             input logic signed [15:0] smp_r);
        play_item(MODE_LOAD, addr, smp_l, smp_r, rand_mix(), rand_mix());
    endtask

    task automatic tick_with(input t_mix mix_l, input t_mix mix_r);
        play_item(MODE_TICK, 16'($urandom), rand_word(), rand_word(), mix_l, mix_r);
    endtask

    task automatic drain_results();
        in_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // Registers change only once the voice has delivered every outstanding beat.
    task automatic apply_setting(input t_voice_setting s);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SAMPLE_LENGTH;
        cfg_data  <= CFG_DATA_W'(s.length);
        @(negedge i_clk);
        cfg_index <= CFG_START_FRACTION;
        cfg_data  <= CFG_DATA_W'(s.start_frac);
        @(negedge i_clk);
        cfg_index <= CFG_END_FRACTION;
        cfg_data  <= CFG_DATA_W'(s.end_frac);
        @(negedge i_clk);
        cfg_index <= CFG_PITCH_RATE;
        cfg_data  <= CFG_DATA_W'(s.pitch);
        @(negedge i_clk);
        cfg_index <= CFG_VOLUME;
        cfg_data  <= CFG_DATA_W'(s.volume);
        @(negedge i_clk);
        cfg_index <= CFG_PAN_LEFT_GAIN;
        cfg_data  <= CFG_DATA_W'(s.pan_left);
        @(negedge i_clk);
        cfg_index <= CFG_PAN_RIGHT_GAIN;
        cfg_data  <= CFG_DATA_W'(s.pan_right);
        @(negedge i_clk);
        cfg_index <= CFG_LOOP_ENABLE;
        cfg_data  <= CFG_DATA_W'(s.loop_on);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial begin : stimulus
        t_voice_setting s;
        int             a;
        int             k;
        int             burst;
        int             pick;
        int             n_random;
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_SAMPLE_LENGTH;
        cfg_data            = '0;
        in_bus.valid        = 1'b0;
        in_bus.mode         = MODE_LOAD;
        in_bus.address      = '0;
        in_bus.sample_left  = '0;
        in_bus.sample_right = '0;
        in_bus.mix_left     = '0;
        in_bus.mix_right    = '0;
        src_idle_on         = 1'b1;
        sink_idle_on        = 1'b1;
        n_random            = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // An empty slot: the mix passes through and a trigger is ignored.
        tick_with(OUT_MAX, OUT_MIN);
        command(MODE_TRIGGER);
        tick_with(OUT_MIN, OUT_MAX);

        load_word(16'd0, 16'sh7FFF, 16'sh8000);
        load_word(16'd1, 16'sh8000, 16'sh7FFF);
        for (a = 2; a < LOW_WORDS; a++) load_word(16'(a), rand_word(), rand_word());
        for (a = HIGH_BASE; a < SAMPLE_DEPTH; a++) load_word(16'(a), rand_word(), rand_word());

        // Full-scale samples at unity gain drive both sums into saturation.
        s = '{17'd8, 16'd0, 17'd65536, 24'h010000, 16'd32768, 16'd32768, 16'd32768, 1'b0};
        apply_setting(s);
        command(MODE_TRIGGER);
        tick_with(OUT_MAX, OUT_MIN);
        tick_with(OUT_MIN, OUT_MAX);
        command(MODE_STOP);
        command(MODE_TICK);

        // A one-shot voice runs off the end of the region and stops.
        s.pitch = 24'h040000;
        apply_setting(s);
        command(MODE_TRIGGER);
        repeat (3) command(MODE_TICK);

        // The start lies past the end, at the fastest pitch; volume and left gain exceed unity.
        s = '{17'd8, 16'hC000, 17'h04000, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 1'b1};
        apply_setting(s);
        command(MODE_TRIGGER);
        repeat (2) command(MODE_TICK);
        s.loop_on = 1'b0;
        apply_setting(s);
        command(MODE_TRIGGER);
        command(MODE_TICK);

        // The length drops to zero while the voice plays, then a load stops it.
        s = '{17'd8, 16'd0, 17'd65536, 24'd0, 16'd32768, 16'd23170, 16'd23170, 1'b0};
        apply_setting(s);
        command(MODE_TRIGGER);
        command(MODE_TICK);
        s.length = 17'd0;
        apply_setting(s);
        command(MODE_TICK);
        command(MODE_TRIGGER);
        load_word(16'd2, rand_word(), rand_word());

        // A length beyond the memory depth, looping over the topmost words.
        s = '{17'h1FFFF, 16'hFFF0, 17'd65536, 24'h040000, 16'd32768, 16'd32768,
              16'd32768, 1'b1};
        apply_setting(s);
        command(MODE_TRIGGER);
        repeat (6) command(MODE_TICK);

        while (n_random < RANDOM_ITEMS) begin
            s            = random_setting();
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            apply_setting(s);
            command(MODE_TRIGGER);
            burst = $urandom_range(20, 50);
            for (k = 0; k < burst; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    command(MODE_TRIGGER);
                end else if (pick < 14) begin
                    command(MODE_STOP);
                end else if (pick < 20) begin
                    load_word(($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, LOW_WORDS - 1)),
                              rand_word(), rand_word());
                end else if (pick < 21) begin
                    drain_results();
                end else begin
                    command(MODE_TICK);
                end
            end
            n_random += burst + 1;
        end

        drain_results();
        repeat (10) @(negedge i_clk);
        $display("covered %0d loads, %0d triggers, %0d stops and %0d ticks in %0d settings",
                 n_load, n_trigger, n_stop, n_tick, n_settings);
        $display("%0d result beats compared, %0d mismatches", checked, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
